/* design/sdm_pkg.sv */
// Shared constants, types and the square-root step for the square-to-disk map.
// No dependencies.
package sdm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = FRAC_BITS + 1;
   localparam int RAD_W     = 24;
   localparam int OUT_W     = 25;
   localparam int RDC_W     = 2 * FRAC_BITS + 1;
   localparam int ROOT_W    = FRAC_BITS + 1;
   localparam int REM_W     = ROOT_W + 2;
   localparam int SQ_BITS   = 2 * ROOT_W;
   localparam int SQ_LAT    = ROOT_W + 1;
   localparam int PIPE_LEN  = SQ_LAT + 9;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 56;

   localparam logic [CRD_W-1:0] ONE  = CRD_W'(1) << FRAC_BITS;
   localparam logic [RDC_W-1:0] ONE2 = RDC_W'(1) << (2 * FRAC_BITS);
   localparam logic [15:0]      INV_SQRT2 = 16'd46341;

   typedef enum logic [1:0] {
      VAR_ZERO  = 2'd0,
      VAR_ARC   = 2'd1,
      VAR_SHIFT = 2'd2,
      VAR_WARP  = 2'd3
   } variant_type;

   typedef enum logic {
      CSR_VARIANT = 1'b0,
      CSR_RADIUS  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SQ_BITS-1:0] rad;
      logic [REM_W-1:0]   rem;
      logic [ROOT_W-1:0]  root;
   } sq_lane_type;

   function automatic sq_lane_type sq_step(input sq_lane_type s);
      sq_lane_type             r;
      logic [REM_W+1:0]        rw;
      logic [REM_W+1:0]        trial;
      rw    = {s.rem, s.rad[SQ_BITS-1 -: 2]};
      trial = (REM_W+2)'({s.root, 2'b01});
      r.rad = {s.rad[SQ_BITS-3:0], 2'b00};
      if (rw >= trial) begin
         r.rem  = REM_W'(rw - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = REM_W'(rw);
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

/* design/square_to_disk_map_unit.sv */
// Square-to-disk map: fold, three mapping formulas, restore and radius scaling.
// Accepts one item per cycle while no output stall holds the pipeline.
// The 18-stage square-root pipeline sets most of the latency.
// Stalls collapse bubbles stage by stage; no item is dropped or repeated.
// Synchronous active-high reset empties the pipeline, variant 3, radius 1.0.
// Depends on sdm_pkg and sdm_sqrt_pipe.
module square_to_disk_map_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // logical_x [16:0], logical_y [33:17], zero fill
   input  logic [sdm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // disk_x [24:0], disk_y [49:25], zero fill
   output logic [sdm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic                               csr_index,
   input  logic [sdm_pkg::RAD_W-1:0]          csr_wdata
);
   import sdm_pkg::*;

   localparam int N = PIPE_LEN;
   localparam int SQ0 = 5;

   typedef struct packed {
      variant_type        v;
      logic               swp;
      logic               nx;
      logic               ny;
      logic               dz;
      logic [CRD_W-1:0]   cpart;
      logic [CRD_W:0]     y;
   } ctx_type;

   function automatic logic [19:0] qmul(input logic [17:0] a, input logic [17:0] b);
      logic [36:0] p;
      p = 37'(a) * 37'(b) + (37'(1) << (FRAC_BITS - 1));
      return 20'(p >> FRAC_BITS);
   endfunction

   variant_type       variant_ff;
   logic [RAD_W-1:0]  radius_ff;
   logic [N-1:0]      vld_ff;
   logic [N-1:0]      en;

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff <= VAR_WARP;
         radius_ff  <= RAD_W'(ONE);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VARIANT: variant_ff <= variant_type'(csr_wdata[1:0]);
            CSR_RADIUS:  radius_ff  <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_tready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= req_tvalid;
         for (int i = 1; i < N; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   assign req_tready = en[0];

   // stage 1: centre, fold, clamp
   logic signed [19:0] xc, yc;
   logic [18:0]        ax, ay, dr, er;
   ctx_type            c1_ff;
   logic [CRD_W-1:0]   d1_ff, e1_ff;

   always_comb begin
      xc = $signed({2'b00, req_tdata[16:0], 1'b0}) - $signed(20'(ONE));
      yc = $signed({2'b00, req_tdata[33:17], 1'b0}) - $signed(20'(ONE));
      ax = xc[19] ? 19'(-xc) : 19'(xc);
      ay = yc[19] ? 19'(-yc) : 19'(yc);
      dr = (ax < ay) ? ay : ax;
      er = (ax < ay) ? ax : ay;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c1_ff.v     <= (variant_ff == VAR_ZERO) ? VAR_WARP : variant_ff;
         c1_ff.swp   <= ax < ay;
         c1_ff.nx    <= xc[19];
         c1_ff.ny    <= yc[19];
         c1_ff.dz    <= dr == '0;
         c1_ff.cpart <= '0;
         c1_ff.y     <= '0;
         d1_ff <= (dr > 19'(ONE)) ? ONE : CRD_W'(dr);
         e1_ff <= (er > 19'(ONE)) ? ONE : CRD_W'(er);
      end
   end

   // stage 2: first products
   ctx_type          c2_ff;
   logic [CRD_W-1:0] dk2_ff, ek2_ff, e2_ff;
   logic [RDC_W-1:0] dsq2_ff;
   logic [17:0]      dt2_ff, tk2_ff;
   logic [17:0]      t1;

   assign t1 = 18'h20000 - 18'(d1_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c2_ff   <= c1_ff;
         e2_ff   <= e1_ff;
         dk2_ff  <= CRD_W'(qmul(18'(d1_ff), 18'(INV_SQRT2)));
         ek2_ff  <= CRD_W'(qmul(18'(e1_ff), 18'(INV_SQRT2)));
         dsq2_ff <= RDC_W'(34'(d1_ff) * 34'(d1_ff));
         dt2_ff  <= 18'(qmul(18'(d1_ff), t1));
         tk2_ff  <= 18'(qmul(t1, 18'(INV_SQRT2)));
      end
   end

   // stage 3: second products, choose y and c term
   ctx_type          c3_ff;
   ctx_type          c3_in;
   logic [CRD_W-1:0] dd3_ff;
   logic [RDC_W-1:0] dsq3_ff;
   logic [CRD_W-1:0] dd2;

   assign dd2 = CRD_W'(qmul(dt2_ff, 18'(INV_SQRT2)));

   always_comb begin
      c3_in = c2_ff;
      if (c2_ff.v == VAR_WARP) begin
         c3_in.y     = 18'(qmul(tk2_ff, 18'(e2_ff)));
         c3_in.cpart = dd2;
      end else begin
         c3_in.y     = 18'(ek2_ff);
         c3_in.cpart = dk2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c3_ff   <= c3_in;
         dsq3_ff <= dsq2_ff;
         dd3_ff  <= dd2;
      end
   end

   // stage 4: squares feeding the radicands
   ctx_type          c4_ff;
   logic [RDC_W-1:0] amin4_ff;
   logic [33:0]      asub4_ff, ysq4_ff;
   logic [33:0]      ysq3;

   assign ysq3 = 34'(36'(c3_ff.y) * 36'(c3_ff.y));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         c4_ff   <= c3_ff;
         ysq4_ff <= ysq3;
         unique case (c3_ff.v)
            VAR_ARC: begin
               amin4_ff <= dsq3_ff;
               asub4_ff <= ysq3;
            end
            VAR_SHIFT: begin
               amin4_ff <= ONE2;
               asub4_ff <= 34'(dsq3_ff >> 1);
            end
            default: begin
               amin4_ff <= ONE2;
               asub4_ff <= 34'(dd3_ff) * 34'(dd3_ff);
            end
         endcase
      end
   end

   // stage 5: radicands, clamped at zero
   logic [RDC_W-1:0] rada5_ff, radb5_ff;
   ctx_type          cq_ff [SQ_LAT + 1];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         cq_ff[0] <= c4_ff;
         rada5_ff <= (34'(amin4_ff) > asub4_ff) ? RDC_W'(34'(amin4_ff) - asub4_ff) : '0;
         radb5_ff <= (34'(ONE2) > ysq4_ff) ? RDC_W'(34'(ONE2) - ysq4_ff) : '0;
      end
      for (int j = 0; j < SQ_LAT; j++) begin
         if (en[SQ0 + j]) cq_ff[j+1] <= cq_ff[j];
      end
   end

   logic [ROOT_W-1:0] root_a, root_b;

   sdm_sqrt_pipe u_sqrt (
      .clock  (clock),
      .en     (en[SQ0 + SQ_LAT - 1 : SQ0]),
      .rad_a  (rada5_ff),
      .rad_b  (radb5_ff),
      .root_a (root_a),
      .root_b (root_b)
   );

   // stage after roots: combine into folded point
   localparam int CS = SQ0 + SQ_LAT;
   ctx_type            c6_ff;
   logic signed [19:0] xp6_ff;
   logic signed [19:0] yp6_ff;
   ctx_type            cs;

   assign cs = cq_ff[SQ_LAT];

   always_ff @(posedge clock) begin
      if (en[CS]) begin
         c6_ff <= cs;
         if (cs.dz) begin
            xp6_ff <= '0;
            yp6_ff <= '0;
         end else begin
            yp6_ff <= $signed(20'(cs.y));
            if (cs.v == VAR_ARC) begin
               xp6_ff <= $signed(20'(root_a));
            end else begin
               xp6_ff <= $signed(20'(cs.cpart)) - $signed(20'(root_a))
                         + $signed(20'(root_b));
            end
         end
      end
   end

   // restore swap and signs, take magnitudes
   logic signed [19:0] rx, ry, fx, fy;
   logic               sx7_ff, sy7_ff;
   logic [18:0]        mx7_ff, my7_ff;

   always_comb begin
      rx = c6_ff.swp ? yp6_ff : xp6_ff;
      ry = c6_ff.swp ? xp6_ff : yp6_ff;
      fx = c6_ff.nx ? -rx : rx;
      fy = c6_ff.ny ? -ry : ry;
   end

   always_ff @(posedge clock) begin
      if (en[CS + 1]) begin
         sx7_ff <= fx[19];
         sy7_ff <= fy[19];
         mx7_ff <= fx[19] ? 19'(-fx) : 19'(fx);
         my7_ff <= fy[19] ? 19'(-fy) : 19'(fy);
      end
   end

   // radius products
   logic        sx8_ff, sy8_ff;
   logic [42:0] px8_ff, py8_ff;

   always_ff @(posedge clock) begin
      if (en[CS + 2]) begin
         sx8_ff <= sx7_ff;
         sy8_ff <= sy7_ff;
         px8_ff <= 43'(mx7_ff) * 43'(radius_ff);
         py8_ff <= 43'(my7_ff) * 43'(radius_ff);
      end
   end

   // round, saturate, sign: output register
   logic [27:0]             sxr, syr;
   logic [RAD_W-1:0]        sxs, sys;
   logic signed [OUT_W-1:0] dx_ff, dy_ff;

   always_comb begin
      sxr = 28'((px8_ff + (43'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      syr = 28'((py8_ff + (43'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      sxs = (sxr > 28'(radius_ff)) ? radius_ff : RAD_W'(sxr);
      sys = (syr > 28'(radius_ff)) ? radius_ff : RAD_W'(syr);
   end

   always_ff @(posedge clock) begin
      if (en[CS + 3]) begin
         dx_ff <= sx8_ff ? -$signed(OUT_W'(sxs)) : $signed(OUT_W'(sxs));
         dy_ff <= sy8_ff ? -$signed(OUT_W'(sys)) : $signed(OUT_W'(sys));
      end
   end

   assign rsp_tvalid = vld_ff[N-1];
   assign rsp_tdata  = {6'b0, dy_ff, dx_ff};

   a_sat_x: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (dx_ff <= $signed({1'b0, radius_ff}) &&
                      dx_ff >= -$signed({1'b0, radius_ff})))
      else $error("disk_x beyond radius");

   a_sat_y: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (dy_ff <= $signed({1'b0, radius_ff}) &&
                      dy_ff >= -$signed({1'b0, radius_ff})))
      else $error("disk_y beyond radius");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty output stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff && !rsp_tready) |-> !req_tready)
      else $error("item taken into a full stalled pipeline");

endmodule

/* design/sdm_sqrt_pipe.sv */
// Two-lane pipelined rounded integer square root, one result bit per stage.
// Depends on sdm_pkg.
module sdm_sqrt_pipe (
   input  logic                              clock,
   input  logic [sdm_pkg::SQ_LAT-1:0]        en,
   input  logic [sdm_pkg::RDC_W-1:0]         rad_a,
   input  logic [sdm_pkg::RDC_W-1:0]         rad_b,
   output logic [sdm_pkg::ROOT_W-1:0]        root_a,
   output logic [sdm_pkg::ROOT_W-1:0]        root_b
);
   import sdm_pkg::*;

   sq_lane_type lane_a_ff [ROOT_W];
   sq_lane_type lane_b_ff [ROOT_W];
   logic [ROOT_W-1:0] root_a_ff, root_b_ff;
   sq_lane_type seed_a, seed_b;

   always_comb begin
      seed_a = '{rad: SQ_BITS'(rad_a), rem: '0, root: '0};
      seed_b = '{rad: SQ_BITS'(rad_b), rem: '0, root: '0};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lane_a_ff[0] <= sq_step(seed_a);
         lane_b_ff[0] <= sq_step(seed_b);
      end
      for (int i = 1; i < ROOT_W; i++) begin
         if (en[i]) begin
            lane_a_ff[i] <= sq_step(lane_a_ff[i-1]);
            lane_b_ff[i] <= sq_step(lane_b_ff[i-1]);
         end
      end
      // round to nearest: remainder above root means sqrt >= root + 1/2
      if (en[SQ_LAT-1]) begin
         root_a_ff <= lane_a_ff[ROOT_W-1].root +
                      ROOT_W'(REM_W'(lane_a_ff[ROOT_W-1].rem) >
                              REM_W'(lane_a_ff[ROOT_W-1].root));
         root_b_ff <= lane_b_ff[ROOT_W-1].root +
                      ROOT_W'(REM_W'(lane_b_ff[ROOT_W-1].rem) >
                              REM_W'(lane_b_ff[ROOT_W-1].root));
      end
   end

   assign root_a = root_a_ff;
   assign root_b = root_b_ff;

endmodule
